// ===== hdl/lfseb_pkg.sv =====
// Shared types and constants for the LED frame store with blinking endpoints.
package lfseb_pkg;

  localparam logic [3:0] OP_CLEAR       = 4'd0;
  localparam logic [3:0] OP_PAINT       = 4'd1;
  localparam logic [3:0] OP_MARK        = 4'd2;
  localparam logic [3:0] OP_RENDER      = 4'd3;
  localparam logic [3:0] OP_TICK        = 4'd4;
  localparam logic [3:0] OP_DIM         = 4'd5;
  localparam logic [3:0] OP_SAVE        = 4'd6;
  localparam logic [3:0] OP_RESTORE     = 4'd7;
  localparam logic [3:0] OP_DROP        = 4'd8;
  localparam logic [3:0] OP_RESET_BLINK = 4'd9;

  localparam logic [15:0] PERIOD_RESET  = 16'd500;
  localparam logic [31:0] ELAPSED_MAX   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [3:0] op;
    logic [9:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] dim_factor;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       blink_phase;
    logic       blink_toggled;
    logic       snapshot_valid;
  } rsp_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } color_t;

  typedef struct packed {
    logic   flag;
    color_t path;
    color_t endc;
  } entry_t;

  // Events handed from the sequencer to the blink timer when a transaction completes.
  typedef struct packed {
    logic tick;
    logic shown;
    logic clear;
    logic blink_reset;
  } evt_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_PIXEL,
    S_SWEEP,
    S_FLUSH,
    S_DONE
  } state_t;

  // c * f / 255, truncated; exact for every 16-bit product.
  function automatic logic [7:0] dim8(input logic [7:0] c, input logic [7:0] f);
    logic [15:0] x;
    logic [16:0] q;
    x = c * f;
    q = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return q[15:8];
  endfunction

  function automatic color_t dim_color(input color_t c, input logic [7:0] f);
    color_t d;
    d.r = dim8(c.r, f);
    d.g = dim8(c.g, f);
    d.b = dim8(c.b, f);
    return d;
  endfunction

endpackage

// ===== hdl/lfseb_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
module lfseb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/lfseb_timer.sv =====
// Blink timer: period register, tick counter, blink phase and frame-shown flag.
module lfseb_timer (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  input  lfseb_pkg::evt_t   evt,
  output logic              phase,
  output logic              phase_after,
  output logic              toggled
);
  import lfseb_pkg::*;

  logic [15:0] period;
  logic [31:0] elapsed;
  logic [31:0] elapsed_inc;
  logic        frame_shown;

  always_comb begin
    elapsed_inc = (elapsed == ELAPSED_MAX) ? elapsed : elapsed + 32'd1;
    toggled     = evt.tick && frame_shown && (elapsed_inc >= {16'd0, period});
    if (evt.blink_reset) begin
      phase_after = 1'b1;
    end else if (toggled) begin
      phase_after = ~phase;
    end else begin
      phase_after = phase;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period      <= PERIOD_RESET;
      elapsed     <= '0;
      phase       <= 1'b1;
      frame_shown <= 1'b0;
    end else begin
      if (cfg_we) begin
        period <= cfg_wdata;
      end
      if (evt.blink_reset) begin
        elapsed <= '0;
      end else if (evt.tick) begin
        elapsed <= toggled ? '0 : elapsed_inc;
      end
      phase <= phase_after;
      if (evt.clear) begin
        frame_shown <= 1'b0;
      end else if (evt.shown) begin
        frame_shown <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/lfseb_ctrl.sv =====
// Sequencer around the live and snapshot frame memories.
module lfseb_ctrl #(
  parameter int LED_COUNT = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  lfseb_pkg::cmd_t   cmd,
  input  logic              slot_free,
  input  logic              phase,
  output logic              idle,
  output logic              fin,
  output lfseb_pkg::color_t shown,
  output logic              held_after,
  output lfseb_pkg::evt_t   evt
);
  import lfseb_pkg::*;

  localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [AW-1:0] LAST = AW'(LED_COUNT - 1);

  state_t        state;
  state_t        state_next;
  cmd_t          item;
  logic [AW-1:0] cnt;
  logic          pend;
  logic [AW-1:0] pend_addr;
  logic          held;

  logic          live_we;
  logic [AW-1:0] live_waddr;
  entry_t        live_wdata;
  logic [AW-1:0] live_raddr;
  entry_t        live_rdata;
  logic          snap_we;
  entry_t        snap_rdata;
  entry_t        src;
  entry_t        mod;

  function automatic logic index_ok(input logic [9:0] ix);
    return {22'd0, ix} < 32'(LED_COUNT);
  endfunction

  lfseb_ram #(.WIDTH($bits(entry_t)), .DEPTH(LED_COUNT)) u_live (
    .clk   (clk),
    .we    (live_we),
    .waddr (live_waddr),
    .wdata (live_wdata),
    .raddr (live_raddr),
    .rdata (live_rdata)
  );

  lfseb_ram #(.WIDTH($bits(entry_t)), .DEPTH(LED_COUNT)) u_snap (
    .clk   (clk),
    .we    (snap_we),
    .waddr (pend_addr),
    .wdata (src),
    .raddr (cnt),
    .rdata (snap_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (cnt == LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          unique case (cmd.op)
            OP_CLEAR, OP_DIM, OP_SAVE: state_next = S_SWEEP;
            OP_RESTORE:                state_next = held ? S_SWEEP : S_DONE;
            OP_PAINT, OP_MARK, OP_RENDER: begin
              state_next = index_ok(cmd.index) ? S_PIXEL : S_DONE;
            end
            default:                   state_next = S_DONE;
          endcase
        end
      end
      S_PIXEL, S_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (cnt == LAST) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: state_next = S_DONE;
    endcase
  end

  // Data moved by a sweep comes from the snapshot only for a restore.
  assign src = (item.op == OP_RESTORE) ? snap_rdata : live_rdata;

  always_comb begin
    idle       = (state == S_IDLE);
    live_we    = 1'b0;
    live_waddr = pend_addr;
    live_wdata = '0;
    snap_we    = 1'b0;
    live_raddr = cnt;
    fin        = 1'b0;
    shown      = '0;
    evt        = '0;
    mod        = live_rdata;
    unique case (state)
      S_INIT: begin
        live_we    = 1'b1;
        live_waddr = cnt;
      end
      S_IDLE: begin
        live_raddr = cmd.index[AW-1:0];
      end
      S_SWEEP, S_FLUSH: begin
        if (state == S_SWEEP && item.op == OP_CLEAR) begin
          live_we    = 1'b1;
          live_waddr = cnt;
        end else if (pend) begin
          if (item.op == OP_DIM) begin
            live_we         = 1'b1;
            live_wdata.flag = src.flag;
            live_wdata.path = dim_color(src.path, item.dim_factor);
            live_wdata.endc = dim_color(src.endc, item.dim_factor);
          end else if (item.op == OP_SAVE) begin
            snap_we = 1'b1;
          end else begin
            live_we    = 1'b1;
            live_wdata = src;
          end
        end
      end
      S_PIXEL: begin
        live_raddr = item.index[AW-1:0];
        live_waddr = item.index[AW-1:0];
        if (slot_free) begin
          fin = 1'b1;
          unique case (item.op)
            OP_PAINT: begin
              mod.path   = '{r: item.red, g: item.green, b: item.blue};
              live_we    = 1'b1;
              live_wdata = mod;
            end
            OP_MARK: begin
              mod.flag   = 1'b1;
              mod.endc   = '{r: item.red, g: item.green, b: item.blue};
              live_we    = 1'b1;
              live_wdata = mod;
            end
            default: begin
              shown     = (live_rdata.flag && phase) ? live_rdata.endc : live_rdata.path;
              evt.shown = 1'b1;
            end
          endcase
        end
      end
      S_DONE: begin
        if (slot_free) begin
          fin             = 1'b1;
          evt.tick        = (item.op == OP_TICK);
          evt.clear       = (item.op == OP_CLEAR);
          evt.blink_reset = (item.op == OP_RESET_BLINK);
        end
      end
    endcase
  end

  always_comb begin
    held_after = held;
    if (fin && item.op == OP_SAVE) begin
      held_after = 1'b1;
    end else if (fin && item.op == OP_DROP) begin
      held_after = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt   <= '0;
      pend  <= 1'b0;
      held  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_INIT || state == S_SWEEP) begin
        cnt <= (cnt == LAST) ? '0 : cnt + AW'(1);
      end else if (start) begin
        cnt <= '0;
      end
      pend <= (state == S_SWEEP) && (item.op != OP_CLEAR);
      held <= held_after;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= cnt;
    if (start) begin
      item <= cmd;
    end
  end

  a_fin_needs_slot: assert property (@(posedge clk) disable iff (rst)
    fin |-> slot_free)
    else $error("result produced while the output register is occupied");

  a_one_store_written: assert property (@(posedge clk) disable iff (rst)
    !(live_we && snap_we))
    else $error("live and snapshot stores written in the same cycle");

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    start |=> state != S_IDLE)
    else $error("accepted transaction did not leave the idle state");

  a_pixel_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_PIXEL) |-> index_ok(item.index))
    else $error("pixel access with an out-of-range index");

endmodule

// ===== hdl/led_frame_store_endpoint_blink_core.sv =====
// Top level of the LED frame store with blinking endpoints.
//
// Commands arrive on the cmd channel (valid/ready); each transaction yields
// exactly one response on the rsp channel (valid/ready), in order.
// Paint, mark, render and the register-only operations (tick, drop, blink
// reset, out-of-range pixels, unused codes) go from S_IDLE to S_PIXEL or
// S_DONE, which loads the response register once it is free. Clear, dim,
// save and restore (restore only while a snapshot is held) sweep the frame
// memory one LED per cycle in S_SWEEP through the write port of the store
// they update, then pass through S_FLUSH to S_DONE and its response.
// A new command is taken once the previous one has been handed to the
// response register, so a response may wait there while the next command
// is already being processed; if the receiver stalls for long, the block
// holds its finished result and stops taking commands.
// After reset the live frame memory is cleared by an S_INIT pass over every
// LED, during which cmd_ready stays low. The blink phase starts on, the period
// register at 500 ticks. The user must write the period register through
// cfg_we and cfg_wdata only while the block is idle; the block does not enforce it.
module led_frame_store_endpoint_blink_core #(
  parameter int LED_COUNT = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  lfseb_pkg::cmd_t cmd,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output lfseb_pkg::rsp_t rsp,
  input  logic            cfg_we,
  input  logic [15:0]     cfg_wdata
);
  import lfseb_pkg::*;

  logic   start;
  logic   idle;
  logic   fin;
  logic   slot_free;
  logic   phase;
  logic   phase_after;
  logic   toggled;
  logic   held_after;
  color_t shown;
  evt_t   evt;
  rsp_t   rsp_next;

  assign cmd_ready = idle;
  assign start     = cmd_valid && idle;
  assign slot_free = !rsp_valid || rsp_ready;

  lfseb_ctrl #(.LED_COUNT(LED_COUNT)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (cmd),
    .slot_free  (slot_free),
    .phase      (phase),
    .idle       (idle),
    .fin        (fin),
    .shown      (shown),
    .held_after (held_after),
    .evt        (evt)
  );

  lfseb_timer u_timer (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .evt         (evt),
    .phase       (phase),
    .phase_after (phase_after),
    .toggled     (toggled)
  );

  always_comb begin
    rsp_next.out_red        = shown.r;
    rsp_next.out_green      = shown.g;
    rsp_next.out_blue       = shown.b;
    rsp_next.blink_phase    = phase_after;
    rsp_next.blink_toggled  = toggled;
    rsp_next.snapshot_valid = held_after;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fin) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      rsp <= rsp_next;
    end
  end

endmodule
